[rtl/tlsc_pkg.sv]
package tlsc_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ITEM_W = 32;
  localparam int POS_W  = 6;
  localparam int LC_W   = 7;
  localparam int STAT_W = 2;
  localparam int POS_CW = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_GET     = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_COMPACT = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_OOR  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic append;
    logic rep_full;
    logic rep_oor;
    logic sel_start;
    logic sel_step;
    logic rd_issue;
    logic remove;
    logic rep_get;
    logic cmp_start;
    logic cmp_step;
    logic cmp_finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic oor;
    logic hit;
    logic cmp_end;
  } dp_stat_t;

endpackage

[rtl/tlsc_ram.sv]
module tlsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tlsc_ctrl.sv]
module tlsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  tlsc_pkg::dp_stat_t stat,
  output tlsc_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import tlsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEL  = 4'b0010,
    S_GETW = 4'b0100,
    S_CMP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_get_r, is_get_nxt;

  always_comb begin
    state_nxt  = state_r;
    is_get_nxt = is_get_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_t'(req_type))
            REQ_APPEND: begin
              if (stat.full) begin
                cmd.rep_full = 1'b1;
              end else begin
                cmd.append = 1'b1;
              end
            end
            REQ_GET, REQ_REMOVE: begin
              if (stat.oor) begin
                cmd.rep_oor = 1'b1;
              end else begin
                cmd.sel_start = 1'b1;
                is_get_nxt    = (req_t'(req_type) == REQ_GET);
                state_nxt     = S_SEL;
              end
            end
            REQ_COMPACT: begin
              cmd.cmp_start = 1'b1;
              state_nxt     = S_CMP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        if (stat.hit) begin
          if (is_get_r) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_GETW;
          end else begin
            cmd.remove = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_GETW: begin
        cmd.rep_get = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (stat.cmp_end) begin
          cmd.cmp_finish = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_get_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_get_r <= is_get_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/tlsc_dp.sv]
module tlsc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlsc_pkg::ctrl_cmd_t                cmd,
  input  logic signed [tlsc_pkg::ITEM_W-1:0] item_value,
  input  logic [tlsc_pkg::POS_W-1:0]         position,
  output tlsc_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output logic [tlsc_pkg::STAT_W-1:0]        out_status,
  output logic signed [tlsc_pkg::ITEM_W-1:0] out_read_value,
  output logic [tlsc_pkg::LC_W-1:0]          out_live_count
);
  import tlsc_pkg::*;

  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [CNT_W-1:0]    wr_r, wr_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                pend_r, pend_nxt;

  logic                      ov_r, ov_nxt;
  status_t                   ostat_r, ostat_nxt;
  logic signed [ITEM_W-1:0]  oval_r, oval_nxt;
  logic [LC_W-1:0]           ocnt_r, ocnt_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic signed [VALUE_BITS-1:0] rdata_s;

  logic scan_valid;
  logic scan_in_fill;

  tlsc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdata_s      = ram_rdata;
  assign scan_valid   = valid_r[scan_r[IDX_W-1:0]];
  assign scan_in_fill = (scan_r < fill_r);

  assign stat.full    = (fill_r == CNT_W'(CAPACITY));
  assign stat.oor     = (POS_CW'(position) >= POS_CW'(cnt_r));
  assign stat.hit     = scan_valid && (POS_CW'(seen_r) == POS_CW'(pos_r));
  assign stat.cmp_end = !scan_in_fill && !pend_r;

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    seen_nxt  = seen_r;
    wr_nxt    = wr_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    ov_nxt    = 1'b0;
    ostat_nxt = ostat_r;
    oval_nxt  = oval_r;
    ocnt_nxt  = ocnt_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[IDX_W-1:0];
    ram_wdata = VALUE_BITS'(item_value);
    ram_re    = 1'b0;
    ram_raddr = scan_r[IDX_W-1:0];

    if (cmd.append) begin
      ram_we                        = 1'b1;
      valid_nxt[fill_r[IDX_W-1:0]]  = 1'b1;
      fill_nxt                      = fill_r + 1'b1;
      cnt_nxt                       = cnt_r + 1'b1;
      ov_nxt                        = 1'b1;
      ostat_nxt                     = STAT_OK;
      oval_nxt                      = '0;
      ocnt_nxt                      = LC_W'(cnt_r + 1'b1);
    end

    if (cmd.rep_full || cmd.rep_oor) begin
      ov_nxt    = 1'b1;
      ostat_nxt = cmd.rep_full ? STAT_FULL : STAT_OOR;
      oval_nxt  = '0;
      ocnt_nxt  = LC_W'(cnt_r);
    end

    if (cmd.sel_start) begin
      scan_nxt = '0;
      seen_nxt = '0;
      pos_nxt  = position;
    end

    if (cmd.sel_step && !stat.hit) begin
      scan_nxt = scan_r + 1'b1;
      seen_nxt = seen_r + CNT_W'(scan_valid);
    end

    if (cmd.rd_issue) begin
      ram_re = 1'b1;
    end

    if (cmd.remove) begin
      valid_nxt[scan_r[IDX_W-1:0]] = 1'b0;
      cnt_nxt                      = cnt_r - 1'b1;
      ov_nxt                       = 1'b1;
      ostat_nxt                    = STAT_OK;
      oval_nxt                     = '0;
      ocnt_nxt                     = LC_W'(cnt_r - 1'b1);
    end

    if (cmd.rep_get) begin
      ov_nxt    = 1'b1;
      ostat_nxt = STAT_OK;
      oval_nxt  = ITEM_W'(rdata_s);
      ocnt_nxt  = LC_W'(cnt_r);
    end

    if (cmd.cmp_start) begin
      scan_nxt = '0;
      wr_nxt   = '0;
      pend_nxt = 1'b0;
    end

    if (cmd.cmp_step) begin
      // read side walks the old slots, write side writes each live word in the cycle after its read
      if (scan_in_fill) begin
        ram_re   = 1'b1;
        pend_nxt = scan_valid;
        scan_nxt = scan_r + 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r) begin
        ram_we    = 1'b1;
        ram_waddr = wr_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        wr_nxt    = wr_r + 1'b1;
      end
    end

    if (cmd.cmp_finish) begin
      for (int k = 0; k < CAPACITY; k++) begin
        valid_nxt[k] = (CNT_W'(k) < wr_r);
      end
      fill_nxt  = wr_r;
      cnt_nxt   = wr_r;
      ov_nxt    = 1'b1;
      ostat_nxt = STAT_OK;
      oval_nxt  = '0;
      ocnt_nxt  = LC_W'(wr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    seen_r  <= seen_nxt;
    wr_r    <= wr_nxt;
    pos_r   <= pos_nxt;
    ostat_r <= ostat_nxt;
    oval_r  <= oval_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_read_value = oval_r;
  assign out_live_count = ocnt_r;

endmodule

[rtl/tombstone_list_select_compact.sv]
// append and rejected requests give their result in the cycle after start
// get and remove scan one slot a cycle up to the selected slot, get then adding
// a registered slot read; compact walks the slots below the fill pointer and ends once the last pending copy is written
// throughput: busy stays low after append and rejected requests, so those run one per cycle
// reset clears valid marks, fill pointer and count at once; no clearing pass
// results are one-cycle strobes, the receiver cannot stall
module tombstone_list_select_compact (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic signed [tlsc_pkg::ITEM_W-1:0] in_item_value,
  input  logic [tlsc_pkg::POS_W-1:0]         in_position,
  output logic                               out_valid,
  output logic [tlsc_pkg::STAT_W-1:0]        out_status,
  output logic signed [tlsc_pkg::ITEM_W-1:0] out_read_value,
  output logic [tlsc_pkg::LC_W-1:0]          out_live_count
);
  import tlsc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tlsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tlsc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .item_value     (in_item_value),
    .position       (in_position),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_live_count (out_live_count)
  );

endmodule

[verif/tb_tombstone_list_select_compact.sv]
`timescale 1ns / 100ps

module tb_tombstone_list_select_compact;
  import tlsc_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [6:0]  live_count;
  } list_resp_t;

  class slot_list_tracker;
    logic [31:0] slot_word[CAPACITY];
    bit          slot_live[CAPACITY];
    int unsigned fill_ptr;
    int unsigned live_total;
    list_resp_t  awaited[$];
    int          mismatches;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_word[i] = '0;
      end
      fill_ptr   = 0;
      live_total = 0;
      mismatches = 0;
    endfunction

    function void take_request(req_t rq, logic [31:0] val, logic [5:0] pos);
      list_resp_t  r;
      int unsigned s;
      int unsigned seen;
      int unsigned w;
      r.status     = STAT_OK;
      r.read_value = '0;
      case (rq)
        REQ_APPEND: begin
          if (fill_ptr >= CAPACITY) begin
            r.status = STAT_FULL;
          end else begin
            slot_word[fill_ptr] = val;
            slot_live[fill_ptr] = 1'b1;
            fill_ptr++;
            live_total++;
          end
        end
        REQ_GET, REQ_REMOVE: begin
          s    = CAPACITY;
          seen = 0;
          if (pos < live_total) begin
            for (int unsigned i = 0; i < fill_ptr; i++) begin
              if (slot_live[i]) begin
                if (seen == pos && s == CAPACITY) s = i;
                seen++;
              end
            end
          end
          if (s >= CAPACITY) begin
            r.status = STAT_OOR;
          end else if (rq == REQ_GET) begin
            r.read_value = slot_word[s];
          end else begin
            slot_live[s] = 1'b0;
            live_total--;
          end
        end
        default: begin
          w = 0;
          for (int unsigned i = 0; i < CAPACITY; i++) begin
            if (i < fill_ptr && slot_live[i]) begin
              slot_word[w] = slot_word[i];
              slot_live[w] = 1'b1;
              w++;
            end
          end
          for (int unsigned i = w; i < CAPACITY; i++) begin
            slot_word[i] = '0;
            slot_live[i] = 1'b0;
          end
          fill_ptr   = w;
          live_total = w;
        end
      endcase
      r.live_count = live_total[6:0];
      awaited.push_back(r);
    endfunction

    function void match_response(logic [1:0] st, logic [31:0] rd, logic [6:0] lc);
      list_resp_t e;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: status %0d read %h live %0d", st, rd, lc);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || rd !== e.read_value || lc !== e.live_count) begin
        if (mismatches < 10)
          $display("result mismatch: status %0d/%0d read %h/%h live %0d/%0d (exp/act)",
                   e.status, st, e.read_value, rd, e.live_count, lc);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_req_type;
  logic signed [31:0] in_item_value;
  logic [5:0]        in_position;
  logic              out_valid;
  logic [1:0]        out_status;
  logic signed [31:0] out_read_value;
  logic [6:0]        out_live_count;

  slot_list_tracker sb;
  int               idle_cycles;

  tombstone_list_select_compact u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_item_value  (in_item_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_live_count (out_live_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.match_response(out_status, out_read_value, out_live_count);
      if (start && !busy) sb.take_request(req_t'(in_req_type), in_item_value, in_position);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tombstone_list_select_compact regression: fail");
        $finish;
      end
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_word(req_t rq, logic [31:0] val, logic [5:0] pos, int gap);
    start         <= 1'b1;
    in_req_type   <= rq;
    in_item_value <= val;
    in_position   <= pos;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_word(int w_app, int w_get, int w_rem, bit quiet);
    int          r;
    req_t        rq;
    logic [31:0] val;
    logic [5:0]  pos;
    r = $urandom_range(0, 99);
    if (r < w_app) rq = REQ_APPEND;
    else if (r < w_app + w_get) rq = REQ_GET;
    else if (r < w_app + w_get + w_rem) rq = REQ_REMOVE;
    else rq = REQ_COMPACT;
    case ($urandom_range(0, 7))
      0: val = 32'h7fff_ffff;
      1: val = 32'h8000_0000;
      2: val = 32'h0000_0000;
      3: val = 32'hffff_ffff;
      default: val = $urandom;
    endcase
    if (sb.live_total > 0 && $urandom_range(0, 7) != 0)
      pos = 6'($urandom_range(0, sb.live_total - 1));
    else
      pos = 6'($urandom_range(0, 63));
    send_word(rq, val, pos, pick_gap(quiet));
  endtask

  initial begin
    int app_w[6];
    int get_w[6];
    int rem_w[6];
    sb = new();
    app_w = '{90, 20, 40, 10, 70, 35};
    get_w = '{10, 35, 30, 30, 15, 30};
    rem_w = '{0, 40, 25, 55, 10, 25};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = '0;
    in_item_value = '0;
    in_position   = '0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, then tombstones skipped by rank select
    send_word(REQ_GET,     $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_REMOVE,  $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_COMPACT, $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_APPEND,  32'h7fff_ffff, 6'd63, pick_gap(1'b0));
    send_word(REQ_APPEND,  32'h8000_0000, 6'd0,  pick_gap(1'b0));
    send_word(REQ_APPEND,  32'h0000_0000, 6'd0,  pick_gap(1'b0));
    send_word(REQ_APPEND,  32'hffff_ffff, 6'd0,  pick_gap(1'b0));
    send_word(REQ_APPEND,  32'h5a5a_5a5a, 6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd3,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd5,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd63, pick_gap(1'b0));
    send_word(REQ_REMOVE,  $urandom,     6'd1,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd1,  pick_gap(1'b0));
    send_word(REQ_REMOVE,  $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_REMOVE,  $urandom,     6'd63, pick_gap(1'b0));
    send_word(REQ_APPEND,  32'ha5a5_a5a5, 6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd3,  pick_gap(1'b0));
    send_word(REQ_COMPACT, $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd0,  pick_gap(1'b0));
    send_word(REQ_GET,     $urandom,     6'd2,  pick_gap(1'b0));
    send_word(REQ_REMOVE,  $urandom,     6'd2,  pick_gap(1'b0));
    send_word(REQ_COMPACT, $urandom,     6'd0,  pick_gap(1'b0));

    for (int ph = 0; ph < 6; ph++) begin
      for (int n = 0; n < 100; n++) begin
        random_word(app_w[ph], get_w[ph], rem_w[ph], ph == 3);
      end
    end

    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("tombstone_list_select_compact regression: pass");
    end else begin
      $display("tombstone_list_select_compact regression: fail");
    end
    $finish;
  end

endmodule
